### sv/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg: shared types and codes of the cursor list store
// Port field widths, operation and status codes, and the control word that
// steers one row of stack cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cls_pkg;

	// port field widths
	localparam int OP_W     = 4;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int ENTRY_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int CURSOR_W = 6;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	// operation codes
	localparam op_t OP_ADD_TAIL  = 4'd0;
	localparam op_t OP_ADD_HEAD  = 4'd1;
	localparam op_t OP_ADD_AFTER = 4'd2;
	localparam op_t OP_GOTO      = 4'd3;
	localparam op_t OP_FIRST     = 4'd4;
	localparam op_t OP_NEXT      = 4'd5;
	localparam op_t OP_PREV      = 4'd6;
	localparam op_t OP_LAST      = 4'd7;
	localparam op_t OP_READ      = 4'd8;
	localparam op_t OP_DELETE    = 4'd9;
	localparam op_t OP_CLEAR     = 4'd10;
	localparam op_t OP_ARM       = 4'd11;

	// status codes
	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_NO_ENTRY = 2'd1;
	localparam status_t STATUS_FULL     = 2'd2;

	// shift control for one row of cells, top of stack at cell zero
	typedef struct packed {
		logic push;
		logic pop;
	} stack_ctl_t;

endpackage

`default_nettype wire

### sv/cls_req_if.sv
// ----------------------------------------------------------------------------
// cls_req_if: request channel of the cursor list store
// Valid/ready handshake carrying operation, value and index.
// ----------------------------------------------------------------------------
`default_nettype none

interface cls_req_if;
	logic                         valid;
	logic                         ready;
	logic [cls_pkg::OP_W-1:0]     operation;
	logic [cls_pkg::VALUE_W-1:0]  value;
	logic [cls_pkg::INDEX_W-1:0]  index;

	modport source (output valid, output operation, output value, output index, input ready);
	modport sink   (input valid, input operation, input value, input index, output ready);
endinterface

`default_nettype wire

### sv/cls_rsp_if.sv
// ----------------------------------------------------------------------------
// cls_rsp_if: result channel of the cursor list store
// Valid/ready handshake carrying the entry, status, count, cursor and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface cls_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cls_pkg::ENTRY_W-1:0]   entry;
	logic [cls_pkg::STATUS_W-1:0]  status;
	logic [cls_pkg::COUNT_W-1:0]   entry_count;
	logic [cls_pkg::CURSOR_W-1:0]  cursor;
	logic                          at_first;
	logic                          at_last;
	logic                          is_empty;

	modport source (output valid, output entry, output status, output entry_count,
		output cursor, output at_first, output at_last, output is_empty, input ready);
	modport sink   (input valid, input entry, input status, input entry_count,
		input cursor, input at_first, input at_last, input is_empty, output ready);
endinterface

`default_nettype wire

### sv/cls_cell.sv
// ----------------------------------------------------------------------------
// cls_cell: one storage cell of a stack row
// Holds one list entry; takes its upper neighbour's word on push and its
// lower neighbour's word on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_cell #(
	parameter int WIDTH = 32
) (
	input  wire logic               clk,
	input  wire cls_pkg::stack_ctl_t ctl,
	input  wire logic [WIDTH-1:0]   from_above,
	input  wire logic [WIDTH-1:0]   from_below,
	output logic      [WIDTH-1:0]   word
);

	logic [WIDTH-1:0] word_q;

	// shift with the row
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			word_q <= from_above;
		end else if (ctl.pop) begin
			word_q <= from_below;
		end
	end

	assign word = word_q;

endmodule

`default_nettype wire

### sv/cls_stack.sv
// ----------------------------------------------------------------------------
// cls_stack: row of cells forming a shift stack
// Cell zero is the top; every cell moves one place on push or pop.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_stack #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                clk,
	input  wire cls_pkg::stack_ctl_t ctl,
	input  wire logic [WIDTH-1:0]    push_word,
	output logic      [WIDTH-1:0]    top_word
);

	logic [WIDTH-1:0] cell_word [DEPTH];

	// chain of cells, each wired to its two neighbours
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] above;
		logic [WIDTH-1:0] below;

		if (i == 0) begin : g_head
			assign above = push_word;
		end else begin : g_body
			assign above = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign below = '0;
		end else begin : g_link
			assign below = cell_word[i+1];
		end

		cls_cell #(.WIDTH(WIDTH)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.from_above (above),
			.from_below (below),
			.word       (cell_word[i])
		);
	end

	assign top_word = cell_word[0];

endmodule

`default_nettype wire

### sv/cursor_list_store.sv
// ----------------------------------------------------------------------------
// cursor_list_store: ordered word list with a cursor
// Gap buffer built from two rows of shift cells: the left row holds the
// entries before the cursor (nearest on top), the right row holds the
// current entry on top and those after it below.
// ----------------------------------------------------------------------------
//
//  channel | dir | words carried
//  --------+-----+--------------------------------------------------------
//  req     | in  | operation, value, index
//  rsp     | out | entry, status, entry_count, cursor, at_first/at_last/is_empty
//
//  An operation runs from acceptance through the sequencer steps in order:
//  a drop for a delete of a present entry, the moves of the cursor (one entry
//  crosses the gap per cycle), an add for a completed add, and the finish.
//  Reset empties the list at once; no clearing pass is needed.
//  A new word is accepted while the previous result waits in the output
//  register; a stalled result holds the sequencer in its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_list_store #(
	parameter int CAPACITY    = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cls_req_if.sink    req,
	cls_rsp_if.source  rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	// list shape and sequencer
	logic                   busy_q;
	logic [CW-1:0]          lcnt_q, rcnt_q, tgt_q;
	logic                   pre_q, post_q;
	logic                   armed_q;
	cls_pkg::status_t       status_q;
	logic                   show_q;
	logic [ENTRY_WIDTH-1:0] w_q;

	// output register
	logic                         out_valid_q;
	logic [cls_pkg::ENTRY_W-1:0]  out_entry_q;
	cls_pkg::status_t             out_status_q;
	logic [cls_pkg::COUNT_W-1:0]  out_count_q;
	logic [cls_pkg::CURSOR_W-1:0] out_cursor_q;
	logic                         out_first_q, out_last_q, out_empty_q;

	logic                   req_fire;
	logic [CW-1:0]          n_cnt;
	logic [63:0]            value_wide;
	logic [ENTRY_WIDTH-1:0] w_in;
	logic [31:0]            idx_wide, n_wide;

	cls_pkg::stack_ctl_t    l_ctl, r_ctl;
	logic [ENTRY_WIDTH-1:0] l_top, r_top, r_push;

	assign req_fire   = req.valid && req.ready;
	assign req.ready  = !busy_q;
	assign n_cnt      = lcnt_q + rcnt_q;
	assign value_wide = 64'(req.value);
	assign w_in       = value_wide[ENTRY_WIDTH-1:0];
	assign idx_wide   = 32'(req.index);
	assign n_wide     = 32'(n_cnt);

	// plan of the accepted word
	logic [CW-1:0]    p_tgt;
	logic             p_pre, p_post, p_show, p_clear, p_arm, p_disarm;
	cls_pkg::status_t p_status;

	always_comb begin
		p_tgt    = lcnt_q;
		p_pre    = 1'b0;
		p_post   = 1'b0;
		p_show   = 1'b0;
		p_clear  = 1'b0;
		p_arm    = 1'b0;
		p_disarm = 1'b0;
		p_status = cls_pkg::STATUS_OK;
		unique case (req.operation)
			cls_pkg::OP_ADD_TAIL, cls_pkg::OP_ADD_HEAD, cls_pkg::OP_ADD_AFTER: begin
				if (n_wide >= 32'(CAPACITY)) begin
					p_status = cls_pkg::STATUS_FULL;
				end else begin
					p_post = 1'b1;
					p_show = 1'b1;
					if (req.operation == cls_pkg::OP_ADD_TAIL) begin
						p_tgt = n_cnt;
					end else if (req.operation == cls_pkg::OP_ADD_HEAD || n_cnt == '0) begin
						p_tgt = '0;
					end else begin
						p_tgt = lcnt_q + CW'(1);
					end
				end
			end
			cls_pkg::OP_GOTO: begin
				if (idx_wide < n_wide) begin
					p_tgt  = CW'(req.index);
					p_show = 1'b1;
				end else begin
					p_status = cls_pkg::STATUS_NO_ENTRY;
				end
			end
			cls_pkg::OP_FIRST, cls_pkg::OP_NEXT: begin
				if (req.operation == cls_pkg::OP_FIRST || armed_q) begin
					p_disarm = 1'b1;
					if (n_cnt != '0) begin
						p_tgt  = '0;
						p_show = 1'b1;
					end else begin
						p_status = cls_pkg::STATUS_NO_ENTRY;
					end
				end else if (rcnt_q > CW'(1)) begin
					p_tgt  = lcnt_q + CW'(1);
					p_show = 1'b1;
				end else begin
					p_status = cls_pkg::STATUS_NO_ENTRY;
				end
			end
			cls_pkg::OP_PREV: begin
				if (lcnt_q != '0) begin
					p_tgt  = lcnt_q - CW'(1);
					p_show = 1'b1;
				end else begin
					p_status = cls_pkg::STATUS_NO_ENTRY;
				end
			end
			cls_pkg::OP_LAST: begin
				if (n_cnt != '0) begin
					p_tgt  = n_cnt - CW'(1);
					p_show = 1'b1;
				end else begin
					p_status = cls_pkg::STATUS_NO_ENTRY;
				end
			end
			cls_pkg::OP_READ: begin
				if (n_cnt != '0) begin
					p_show = 1'b1;
				end else begin
					p_status = cls_pkg::STATUS_NO_ENTRY;
				end
			end
			cls_pkg::OP_DELETE: begin
				if (n_cnt == '0) begin
					p_status = cls_pkg::STATUS_NO_ENTRY;
				end else begin
					p_pre = 1'b1;
					if (n_cnt == CW'(1)) begin
						p_status = cls_pkg::STATUS_NO_ENTRY;
					end else begin
						p_show = 1'b1;
						// deleting the tail leaves the cursor on the new last entry
						if (rcnt_q == CW'(1)) begin
							p_tgt = lcnt_q - CW'(1);
						end
					end
				end
			end
			cls_pkg::OP_CLEAR: begin
				p_clear = 1'b1;
				p_tgt   = '0;
			end
			cls_pkg::OP_ARM: begin
				p_arm = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// one step of the sequencer: drop, move across the gap, add, or finish
	logic          finish;
	logic [CW-1:0] lcnt_d, rcnt_d;

	always_comb begin
		l_ctl  = '0;
		r_ctl  = '0;
		r_push = l_top;
		lcnt_d = lcnt_q;
		rcnt_d = rcnt_q;
		finish = 1'b0;
		if (busy_q) begin
			priority if (pre_q) begin
				r_ctl.pop = 1'b1;
				rcnt_d    = rcnt_q - CW'(1);
			end else if (lcnt_q < tgt_q) begin
				r_ctl.pop  = 1'b1;
				l_ctl.push = 1'b1;
				lcnt_d     = lcnt_q + CW'(1);
				rcnt_d     = rcnt_q - CW'(1);
			end else if (lcnt_q > tgt_q) begin
				l_ctl.pop  = 1'b1;
				r_ctl.push = 1'b1;
				lcnt_d     = lcnt_q - CW'(1);
				rcnt_d     = rcnt_q + CW'(1);
			end else if (post_q) begin
				r_ctl.push = 1'b1;
				r_push     = w_q;
				rcnt_d     = rcnt_q + CW'(1);
			end else begin
				finish = !out_valid_q || rsp.ready;
			end
		end
	end

	cls_stack #(.DEPTH(CAPACITY), .WIDTH(ENTRY_WIDTH)) u_left (
		.clk       (clk),
		.ctl       (l_ctl),
		.push_word (r_top),
		.top_word  (l_top)
	);

	cls_stack #(.DEPTH(CAPACITY), .WIDTH(ENTRY_WIDTH)) u_right (
		.clk       (clk),
		.ctl       (r_ctl),
		.push_word (r_push),
		.top_word  (r_top)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			lcnt_q  <= '0;
			rcnt_q  <= '0;
			tgt_q   <= '0;
			pre_q   <= 1'b0;
			post_q  <= 1'b0;
			armed_q <= 1'b0;
		end else if (req_fire) begin
			busy_q <= 1'b1;
			tgt_q  <= p_tgt;
			pre_q  <= p_pre;
			post_q <= p_post;
			if (p_clear) begin
				lcnt_q <= '0;
				rcnt_q <= '0;
			end
			if (p_arm) begin
				armed_q <= 1'b1;
			end else if (p_disarm) begin
				armed_q <= 1'b0;
			end
		end else if (busy_q) begin
			lcnt_q <= lcnt_d;
			rcnt_q <= rcnt_d;
			if (pre_q) begin
				pre_q <= 1'b0;
			end else if (lcnt_q == tgt_q && post_q) begin
				post_q <= 1'b0;
			end
			if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	// word data of the request in flight
	always_ff @(posedge clk) begin
		if (req_fire) begin
			w_q      <= w_in;
			status_q <= p_status;
			show_q   <= p_show;
		end
	end

	// result formatting
	logic [63:0] top_wide;
	logic [31:0] cnt_wide, pos_wide;

	assign top_wide = 64'(r_top);
	assign cnt_wide = 32'(n_cnt);
	assign pos_wide = 32'(lcnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_entry_q  <= show_q ? top_wide[cls_pkg::ENTRY_W-1:0] : '0;
			out_status_q <= status_q;
			out_count_q  <= cnt_wide[cls_pkg::COUNT_W-1:0];
			out_cursor_q <= pos_wide[cls_pkg::CURSOR_W-1:0];
			out_first_q  <= (lcnt_q == '0);
			out_last_q   <= (rcnt_q == CW'(1));
			out_empty_q  <= (n_cnt == '0);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.entry       = out_entry_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.cursor      = out_cursor_q;
	assign rsp.at_first    = out_first_q;
	assign rsp.at_last     = out_last_q;
	assign rsp.is_empty    = out_empty_q;

endmodule

`default_nettype wire
